// File: rtl/core/mcchc_pkg.sv
// Shared constants, widths and the xorshift32 step for the circle hit counter.
package mcchc_pkg;

    localparam int STATE_W        = 32;
    localparam int SEED_W         = 64;
    localparam int SEED_REGS      = 4;
    localparam int SEED_IDX_W     = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int SEED_SRC_LANES = 8;
    localparam int LANES_PER_PAIR = 2;
    localparam int TOTAL_W        = 48;
    localparam int HITS_W         = 4;

    localparam logic [SEED_W-1:0]  SEED_RESET = 64'h0000_0001_0000_0001;
    localparam logic [HITS_W-1:0]  HITS_MAX   = 4'd15;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX  = {TOTAL_W{1'b1}};

    localparam int XS_SHIFT_A = 13;
    localparam int XS_SHIFT_B = 17;
    localparam int XS_SHIFT_C = 5;

    function automatic logic [STATE_W-1:0] xorshift32(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] t;
        t = s ^ (s << XS_SHIFT_A);
        t = t ^ (t >> XS_SHIFT_B);
        t = t ^ (t << XS_SHIFT_C);
        return t;
    endfunction

    function automatic logic [STATE_W-1:0] seed_half(input logic [SEED_W-1:0] pair,
                                                     input logic             upper);
        return upper ? pair[SEED_W-1:STATE_W] : pair[STATE_W-1:0];
    endfunction

endpackage

// File: rtl/core/monte_carlo_circle_hit_counter.sv
// Top level: seed registers, lane array, hit count and saturating running total.
//
//  port group                            | dir | words
//  in_valid/in_stall/restart/final_req   | in  | one round request
//  out_valid/out_stall/round_hits/...    | out | one round result
//  cfg_wr_en/cfg_index/cfg_data          | in  | seed pair writes, no handshake
//
// One round per cycle while out_stall is low; out_valid rises once the round is loaded into the result register.
// The input register holds the request; lanes, hit count and total settle in one pass
// into the result register. Lane state and total advance when the result is loaded.
// Reset loads every lane from the seed reset value and clears the total.
// out_stall holds the result register; the input register then holds its word and
// in_stall rises while it is full.
module monte_carlo_circle_hit_counter #(
    parameter int LANES      = 8,
    parameter int COORD_BITS = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    input  logic                            final_req,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mcchc_pkg::HITS_W-1:0]    round_hits,
    output logic [mcchc_pkg::TOTAL_W-1:0]   total_hits,
    output logic                            run_done,
    input  logic                            cfg_wr_en,
    input  logic [mcchc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcchc_pkg::SEED_W-1:0]    cfg_data
);
    import mcchc_pkg::*;

    localparam int CNT_W = $clog2(LANES + 1);

    logic [SEED_W-1:0]  seed_pair_reg [SEED_REGS];
    logic [STATE_W-1:0] lane_state_reg [LANES];
    logic [STATE_W-1:0] lane_start [LANES];
    logic [STATE_W-1:0] lane_next [LANES];
    logic [LANES-1:0]   lane_hit;

    logic               s1_valid_reg;
    logic               s1_restart_reg;
    logic               s1_final_reg;
    logic               out_valid_reg;
    logic [HITS_W-1:0]  round_hits_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               run_done_reg;

    logic               out_ready;
    logic               in_ready;
    logic               adv;
    logic [CNT_W-1:0]   hit_cnt;
    logic [TOTAL_W-1:0] cnt_ext;
    logic [TOTAL_W-1:0] total_base;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_next;
    logic [HITS_W-1:0]  round_hits_next;

    assign out_ready = !out_valid_reg || !out_stall;
    assign in_ready  = !s1_valid_reg || out_ready;
    assign adv       = s1_valid_reg && out_ready;
    assign in_stall  = !in_ready;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            localparam int SRC = g % SEED_SRC_LANES;
            localparam logic [SEED_IDX_W-1:0] PAIR = SEED_IDX_W'(SRC / LANES_PER_PAIR);
            localparam logic UPPER = (SRC % LANES_PER_PAIR) != 0;

            assign lane_start[g] = s1_restart_reg ? seed_half(seed_pair_reg[PAIR], UPPER)
                                                  : lane_state_reg[g];

            mcchc_lane #(
                .COORD_BITS(COORD_BITS)
            ) u_lane (
                .state_in (lane_start[g]),
                .state_out(lane_next[g]),
                .hit      (lane_hit[g])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    lane_state_reg[g] <= seed_half(SEED_RESET, UPPER);
                end
                else if (adv)
                begin
                    lane_state_reg[g] <= lane_next[g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        hit_cnt = '0;
        for (int i = 0; i < LANES; i++)
        begin
            hit_cnt = hit_cnt + CNT_W'(lane_hit[i]);
        end
        cnt_ext    = TOTAL_W'(hit_cnt);
        total_base = s1_restart_reg ? '0 : total_reg;
        total_sum  = {1'b0, total_base} + {1'b0, cnt_ext};
        total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        round_hits_next = (cnt_ext > TOTAL_W'(HITS_MAX)) ? HITS_MAX : cnt_ext[HITS_W-1:0];
    end

    // seed registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SEED_REGS; k++)
            begin
                seed_pair_reg[k] <= SEED_RESET;
            end
        end
        else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(SEED_REGS)))
        begin
            seed_pair_reg[cfg_index[SEED_IDX_W-1:0]] <= cfg_data;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (adv)
            begin
                total_reg <= total_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_restart_reg <= restart;
            s1_final_reg   <= final_req;
        end
        if (adv)
        begin
            round_hits_reg <= round_hits_next;
            run_done_reg   <= s1_final_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign round_hits = round_hits_reg;
    assign total_hits = total_reg;
    assign run_done   = run_done_reg;

endmodule

// File: rtl/core/mcchc_lane.sv
// One lane: two xorshift32 steps drawing x and y, then the quarter-circle test.
module mcchc_lane #(
    parameter int COORD_BITS = 15
) (
    input  logic [mcchc_pkg::STATE_W-1:0] state_in,
    output logic [mcchc_pkg::STATE_W-1:0] state_out,
    output logic                          hit
);
    import mcchc_pkg::*;

    localparam int SQ_W = 2 * COORD_BITS;
    localparam logic [SQ_W:0] RADIUS = (SQ_W + 1)'((1 << COORD_BITS) - 1);
    localparam logic [SQ_W:0] LIMIT  = RADIUS * RADIUS + (SQ_W + 1)'(1);

    logic [STATE_W-1:0]    step_x;
    logic [STATE_W-1:0]    step_y;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SQ_W-1:0]       x_sq;
    logic [SQ_W-1:0]       y_sq;
    logic [SQ_W:0]         dist_sq;

    assign step_x    = xorshift32(state_in);
    assign step_y    = xorshift32(step_x);
    assign x         = step_x[COORD_BITS-1:0];
    assign y         = step_y[COORD_BITS-1:0];
    assign x_sq      = SQ_W'(x) * SQ_W'(x);
    assign y_sq      = SQ_W'(y) * SQ_W'(y);
    assign dist_sq   = {1'b0, x_sq} + {1'b0, y_sq};
    assign hit       = dist_sq < LIMIT;
    assign state_out = step_y;

endmodule

// File: verif/monte_carlo_circle_hit_counter_checker.sv
`timescale 1ns / 1ps
// Checker for the circle hit counter: mirrors the lanes and the total and checks each result word.
module monte_carlo_circle_hit_counter_checker #(
    parameter int LANES      = 8,
    parameter int COORD_BITS = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            restart,
    input  logic                            final_req,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [mcchc_pkg::HITS_W-1:0]    round_hits,
    input  logic [mcchc_pkg::TOTAL_W-1:0]   total_hits,
    input  logic                            run_done,
    input  logic                            cfg_wr_en,
    input  logic [mcchc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcchc_pkg::SEED_W-1:0]    cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              checked
);
    import mcchc_pkg::*;

    typedef struct packed {
        logic [HITS_W-1:0]  hits;
        logic [TOTAL_W-1:0] total;
        logic               done;
    } tally_t;

    localparam longint unsigned RADIUS    = (64'd1 << COORD_BITS) - 64'd1;
    localparam longint unsigned HIT_LIMIT = RADIUS * RADIUS + 64'd1;

    logic [SEED_W-1:0]  seed_copy [SEED_REGS];
    logic [STATE_W-1:0] lane_word [LANES];
    logic [TOTAL_W-1:0] hit_total;
    tally_t             awaited_tallies [$];

    function automatic logic [STATE_W-1:0] xs_step(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] t;
        t = s ^ (s << XS_SHIFT_A);
        t = t ^ (t >> XS_SHIFT_B);
        t = t ^ (t << XS_SHIFT_C);
        return t;
    endfunction

    function automatic logic [STATE_W-1:0] seed_of(input int lane);
        int          src;
        logic [SEED_W-1:0] pair;
        src  = lane % SEED_SRC_LANES;
        pair = seed_copy[src / LANES_PER_PAIR];
        return (src % LANES_PER_PAIR) != 0 ? pair[SEED_W-1:STATE_W] : pair[STATE_W-1:0];
    endfunction

    function automatic void reload_lanes();
        for (int i = 0; i < LANES; i++)
        begin
            lane_word[i] = seed_of(i);
        end
    endfunction

    function automatic tally_t play_round(input logic rs, input logic fr);
        tally_t             t;
        int                 hits;
        logic [STATE_W-1:0] s;
        longint unsigned    x;
        longint unsigned    y;
        logic [TOTAL_W-1:0] gain;
        if (rs)
        begin
            reload_lanes();
            hit_total = '0;
        end
        hits = 0;
        for (int i = 0; i < LANES; i++)
        begin
            s = xs_step(lane_word[i]);
            x = {32'd0, s} & RADIUS;
            s = xs_step(s);
            y = {32'd0, s} & RADIUS;
            lane_word[i] = s;
            if (x * x + y * y < HIT_LIMIT)
            begin
                hits++;
            end
        end
        gain = TOTAL_W'(hits);
        if (hit_total > TOTAL_MAX - gain)
        begin
            hit_total = TOTAL_MAX;
        end
        else
        begin
            hit_total = hit_total + gain;
        end
        t.hits  = (hits > HITS_MAX) ? HITS_MAX : hits[HITS_W-1:0];
        t.total = hit_total;
        t.done  = fr;
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        tally_t want;
        int     errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int k = 0; k < SEED_REGS; k++)
            begin
                seed_copy[k] = SEED_RESET;
            end
            reload_lanes();
            hit_total = '0;
            awaited_tallies.delete();
            mismatches  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index < SEED_REGS)
            begin
                seed_copy[cfg_index[SEED_IDX_W-1:0]] = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                awaited_tallies.push_back(play_round(restart, final_req));
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_tallies.size() == 0)
                begin
                    $display("%0t: unexpected result word hits %0d total %0d done %0b",
                             $time, round_hits, total_hits, run_done);
                    errs++;
                end
                else
                begin
                    want = awaited_tallies.pop_front();
                    if (round_hits !== want.hits)
                    begin
                        $display("%0t: round_hits expected %0d got %0d",
                                 $time, want.hits, round_hits);
                        errs++;
                    end
                    if (total_hits !== want.total)
                    begin
                        $display("%0t: total_hits expected %0d got %0d",
                                 $time, want.total, total_hits);
                        errs++;
                    end
                    if (run_done !== want.done)
                    begin
                        $display("%0t: run_done expected %0b got %0b",
                                 $time, want.done, run_done);
                        errs++;
                    end
                end
                checked <= checked + 1;
            end
            mismatches  <= mismatches + errs;
            outstanding <= awaited_tallies.size();
        end
    end

endmodule

// File: verif/monte_carlo_circle_hit_counter_test.sv
`timescale 1ns / 1ps
// Testbench top for the circle hit counter: clock, reset, seed writes, round stimulus, verdict.
module monte_carlo_circle_hit_counter_test;
    import mcchc_pkg::*;

    localparam int LATENCY      = 1;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ROUND_TARGET = 1350;
    localparam int IDLE_PCT     = 27;
    localparam int STEADY_PHASE = 6;
    localparam int CFG_SLOTS    = 2 ** CFG_IDX_W;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  restart;
    logic                  final_req;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [HITS_W-1:0]     round_hits;
    logic [TOTAL_W-1:0]    total_hits;
    logic                  run_done;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SEED_W-1:0]     cfg_data;

    logic        steady = 1'b0;
    int unsigned cycle_count = 0;
    int          mismatches;
    int          outstanding;
    int          checked;
    int          rounds_sent = 0;
    int          restarts_sent = 0;
    int          finals_sent = 0;
    int          seed_writes = 0;

    monte_carlo_circle_hit_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .restart    (restart),
        .final_req  (final_req),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .round_hits (round_hits),
        .total_hits (total_hits),
        .run_done   (run_done),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    monte_carlo_circle_hit_counter_checker tally_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .final_req   (final_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .round_hits  (round_hits),
        .total_hits  (total_hits),
        .run_done    (run_done),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("monte_carlo_circle_hit_counter test failed");
            $finish;
        end
    end

    task automatic send_round(input logic rs, input logic fr);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        restart   <= rs;
        final_req <= fr;
        do @(posedge clk); while (in_stall);
        rounds_sent++;
        restarts_sent += rs;
        finals_sent   += fr;
    endtask

    task automatic write_seed(input logic [CFG_IDX_W-1:0] idx, input logic [SEED_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        seed_writes++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic [SEED_W-1:0] random_pair();
        logic [SEED_W-1:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
        begin
            v[STATE_W-1:0] = '0;
        end
        if ($urandom_range(7) == 0)
        begin
            v[SEED_W-1:STATE_W] = '0;
        end
        return v;
    endfunction

    task automatic play_run(input int len, input logic lead_restart, input logic close_final);
        logic rs;
        logic fr;
        for (int i = 0; i < len; i++)
        begin
            rs = (i == 0) ? lead_restart : ($urandom_range(99) < 4);
            fr = (i == len - 1) ? close_final : ($urandom_range(99) < 4);
            send_round(rs, fr);
        end
    endtask

    initial
    begin
        int len;
        int phase;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        final_req <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lanes start from the reset seeds
        send_round(1'b0, 1'b0);
        send_round(1'b0, 1'b0);
        send_round(1'b0, 1'b1);
        drain();

        // drop writes to unmapped indexes
        for (int k = SEED_REGS; k < CFG_SLOTS; k++)
        begin
            write_seed(CFG_IDX_W'(k), {$urandom, $urandom});
        end
        send_round(1'b1, 1'b0);
        send_round(1'b0, 1'b1);
        drain();

        // zero seeds take effect only at restart
        for (int k = 0; k < SEED_REGS; k++)
        begin
            write_seed(CFG_IDX_W'(k), '0);
        end
        send_round(1'b0, 1'b0);
        send_round(1'b1, 1'b0);
        send_round(1'b0, 1'b0);
        send_round(1'b1, 1'b1);
        drain();

        for (int k = 0; k < SEED_REGS; k++)
        begin
            write_seed(CFG_IDX_W'(k), '1);
        end
        send_round(1'b1, 1'b0);
        send_round(1'b0, 1'b0);
        send_round(1'b0, 1'b1);
        drain();

        for (int k = 0; k < SEED_REGS; k++)
        begin
            write_seed(CFG_IDX_W'(k), (k == 0) ? 64'h0000_0000_FFFF_FFFF :
                                      (k == SEED_REGS - 1) ? 64'h8000_0000_0000_0001 :
                                      {$urandom, $urandom});
        end
        send_round(1'b1, 1'b1);
        send_round(1'b1, 1'b0);
        send_round(1'b0, 1'b1);
        drain();

        phase = 0;
        while (rounds_sent < ROUND_TARGET)
        begin
            for (int k = 0; k < SEED_REGS; k++)
            begin
                if ($urandom_range(99) < 60)
                begin
                    write_seed(CFG_IDX_W'(k), random_pair());
                end
            end
            if ($urandom_range(99) < 15)
            begin
                write_seed(CFG_IDX_W'($urandom_range(CFG_SLOTS - 1, SEED_REGS)),
                           {$urandom, $urandom});
            end
            steady <= (phase == STEADY_PHASE);
            len = (phase == STEADY_PHASE) ? 200 : $urandom_range(60, 1);
            play_run(len, $urandom_range(99) < 85, $urandom_range(99) < 80);
            drain();
            phase++;
        end
        steady <= 1'b0;

        $display("Sent %0d rounds (%0d restarts, %0d run ends) over %0d seed writes;",
                 rounds_sent, restarts_sent, finals_sent, seed_writes);
        $display("%0d result words checked against the lane mirror.", checked);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("monte_carlo_circle_hit_counter test passed");
        end
        else
        begin
            $display("monte_carlo_circle_hit_counter test failed");
        end
        $finish;
    end

endmodule
